>>> hdl/scb_pkg.sv
`timescale 1ns / 1ps

package scb_pkg;

   // Field widths
   localparam int OP_W      = 3;
   localparam int SLOT_W    = 4;
   localparam int VALUE_W   = 32;
   localparam int KIND_W    = 2;
   localparam int DATA_W    = 64;
   localparam int ACTIVE_W  = 5;
   localparam int PADDR_W   = 2;
   localparam int PDATA_W   = 32;

   localparam int DEF_NUM_SLOTS = 16;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

   // Register addresses
   localparam logic [PADDR_W-1:0] CSR_ACTIVE_ADDR = 2'd0;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INC  = 3'd0;
   localparam logic [OP_W-1:0] OP_SET  = 3'd1;
   localparam logic [OP_W-1:0] OP_MAX  = 3'd2;
   localparam logic [OP_W-1:0] OP_MIN  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ = 3'd4;

   // Reduction kinds
   localparam logic [KIND_W-1:0] RED_SUM = 2'd0;
   localparam logic [KIND_W-1:0] RED_MAX = 2'd1;
   localparam logic [KIND_W-1:0] RED_MIN = 2'd2;
   localparam logic [KIND_W-1:0] RED_AVG = 2'd3;

   // Shared unit functions
   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_MAX,
      ALU_MIN,
      ALU_PASS
   } alu_op_type;

   // Divider iteration count
   localparam int DIV_CNT_W = 7;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'd64;

endpackage

>>> hdl/scb_alu.sv
`timescale 1ns / 1ps

module scb_alu
   import scb_pkg::*;
(
   input  alu_op_type        op,
   input  logic [DATA_W-1:0] a,
   input  logic [DATA_W-1:0] b,
   output logic [DATA_W-1:0] y
);

   logic a_lt_b;

   assign a_lt_b = $signed(a) < $signed(b);

   always_comb begin
      case (op)
         ALU_ADD:  y = a + b;
         ALU_MAX:  y = a_lt_b ? b : a;
         ALU_MIN:  y = (!a_lt_b && (a != b)) ? b : a;
         ALU_PASS: y = b;
         default:  y = a;
      endcase
   end

endmodule

>>> hdl/scb_bank.sv
`timescale 1ns / 1ps

module scb_bank
   import scb_pkg::*;
#(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS,
   parameter int ADDR_W    = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0]    mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [DATA_W-1:0]    rd_data_ff;

   // Entry never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/scb_div.sv
`timescale 1ns / 1ps

module scb_div
   import scb_pkg::*;
#(
   parameter int CNT_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [CNT_W:0]       trial;
   logic [CNT_W:0]       diff;
   logic                 fits;

   // One quotient bit a cycle, restoring
   assign trial = {rem_ff, quo_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = DIV_STEPS;
         rem_in = '0;
         quo_in = dividend;
      end else if (run_ff) begin
         rem_in = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/sharded_counter_bank_with_reduction.sv
`timescale 1ns / 1ps

// Bank of NUM_SLOTS signed 64-bit counters with one-slot updates and
// reductions over the active slots. A word is taken when start is high and
// busy is low. Updates (increment, set, keep max, keep min) first read the
// slot from the counter memory, then write it back through the shared
// arithmetic unit. Updates to a slot at or beyond the active count and
// unused operation codes are dropped on the spot without raising busy.
// A read walks the active slots one per cycle through the same unit (the
// active count is active_slots clamped to 1..NUM_SLOTS); sum, max and min
// deliver their word at the end of the walk, and average then adds a 64-step
// bit-serial divider. The result is on rsp_aggregate for exactly one cycle
// with rsp_strobe high and must be taken then: the receiver has no way to
// stall it. Write active_slots only while busy is low.

module sharded_counter_bank_with_reduction
   import scb_pkg::*;
#(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [OP_W-1:0]           req_operation,
   input  logic [SLOT_W-1:0]         req_slot,
   input  logic signed [VALUE_W-1:0] req_update_value,
   input  logic [KIND_W-1:0]         req_reduce_kind,
   output logic                      rsp_strobe,
   output logic signed [DATA_W-1:0]  rsp_aggregate,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [PADDR_W-1:0]        paddr,
   input  logic [PDATA_W-1:0]        pwdata,
   output logic [PDATA_W-1:0]        prdata,
   output logic                      pready
);

   localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int CMP_W  = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
   localparam int SEXT_W = (ADDR_W > SLOT_W) ? ADDR_W : SLOT_W;

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPD    = 3'd1;
   localparam logic [2:0] ST_RED    = 3'd2;
   localparam logic [2:0] ST_DSTART = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [ACTIVE_W-1:0] active_ff, active_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [ADDR_W-1:0]   slot_ff, slot_in;
   logic [DATA_W-1:0]   val_ff, val_in;
   logic [ADDR_W-1:0]   walk_ff, walk_in;
   logic [ADDR_W-1:0]   last_ff, last_in;
   logic [DATA_W-1:0]   acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_W-1:0]   rsp_ff, rsp_in;

   logic [CMP_W-1:0]    active_ext;
   logic [CMP_W-1:0]    n_wide;
   logic [CNT_W-1:0]    n_eff;
   logic [SEXT_W-1:0]   slot_ext;
   logic                slot_ok;
   logic                accept;
   logic                csr_wr;

   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [DATA_W-1:0]   rd_data;
   logic                wr_en;

   alu_op_type          alu_op;
   logic [DATA_W-1:0]   alu_a, alu_b, alu_y;
   logic [DATA_W-1:0]   red_next;

   logic                div_start;
   logic [DATA_W-1:0]   div_dividend;
   logic                div_done;
   logic [DATA_W-1:0]   div_quo;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr == CSR_ACTIVE_ADDR);
   assign active_in = csr_wr ? pwdata[ACTIVE_W-1:0] : active_ff;
   assign prdata = (paddr == CSR_ACTIVE_ADDR) ? PDATA_W'(active_ff) : '0;

   // Clamp the active count to 1..NUM_SLOTS
   assign active_ext = CMP_W'(active_ff);
   always_comb begin
      if (active_ext == '0) begin
         n_wide = CMP_W'(1);
      end else if (active_ext > CMP_W'(NUM_SLOTS)) begin
         n_wide = CMP_W'(NUM_SLOTS);
      end else begin
         n_wide = active_ext;
      end
   end
   assign n_eff = n_wide[CNT_W-1:0];

   assign slot_ext = SEXT_W'(req_slot);
   assign slot_ok  = CMP_W'(req_slot) < n_wide;
   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);

   // ---------------- shared arithmetic unit ----------------
   always_comb begin
      alu_a  = acc_ff;
      alu_b  = rd_data;
      alu_op = ALU_ADD;
      if (state_ff == ST_UPD) begin
         alu_a = rd_data;
         case (op_ff)
            OP_INC: begin
               alu_b  = DATA_W'(1);
               alu_op = ALU_ADD;
            end
            OP_SET: begin
               alu_b  = val_ff;
               alu_op = ALU_PASS;
            end
            OP_MAX: begin
               alu_b  = val_ff;
               alu_op = ALU_MAX;
            end
            default: begin
               alu_b  = val_ff;
               alu_op = ALU_MIN;
            end
         endcase
      end else begin
         case (kind_ff)
            RED_MAX: alu_op = ALU_MAX;
            RED_MIN: alu_op = ALU_MIN;
            default: alu_op = ALU_ADD;
         endcase
      end
   end

   scb_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   // First slot seeds the accumulator
   assign red_next = (walk_ff == '0) ? rd_data : alu_y;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      kind_in       = kind_ff;
      slot_in       = slot_ff;
      val_in        = val_ff;
      walk_in       = walk_ff;
      last_in       = last_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = walk_ff;
      wr_en         = 1'b0;
      div_start     = 1'b0;
      div_dividend  = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_operation;
               kind_in = req_reduce_kind;
               slot_in = slot_ext[ADDR_W-1:0];
               val_in  = DATA_W'(req_update_value);
               if ((req_operation == OP_INC || req_operation == OP_SET ||
                    req_operation == OP_MAX || req_operation == OP_MIN) && slot_ok) begin
                  // Fetch the slot, modify next cycle
                  rd_en    = 1'b1;
                  rd_addr  = slot_ext[ADDR_W-1:0];
                  state_in = ST_UPD;
               end else if (req_operation == OP_READ) begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  walk_in  = '0;
                  last_in  = ADDR_W'(n_eff - 1'b1);
                  state_in = ST_RED;
               end
            end
         end
         ST_UPD: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_RED: begin
            acc_in = red_next;
            if (walk_ff == last_ff) begin
               if (kind_ff == RED_AVG) begin
                  state_in = ST_DSTART;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = red_next;
                  state_in      = ST_IDLE;
               end
            end else begin
               // Advance to the next slot
               rd_en   = 1'b1;
               rd_addr = walk_ff + 1'b1;
               walk_in = walk_ff + 1'b1;
            end
         end
         ST_DSTART: begin
            // Divide the magnitude, restore the sign afterwards
            neg_in       = acc_ff[DATA_W-1];
            div_dividend = acc_ff[DATA_W-1] ? (~acc_ff + 1'b1) : acc_ff;
            div_start    = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = neg_ff ? (~div_quo + 1'b1) : div_quo;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= ACTIVE_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      kind_ff <= kind_in;
      slot_ff <= slot_in;
      val_ff  <= val_in;
      walk_ff <= walk_in;
      last_ff <= last_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   // ---------------- counter memory ----------------
   scb_bank #(
      .NUM_SLOTS (NUM_SLOTS),
      .ADDR_W    (ADDR_W)
   ) u_bank (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (alu_y)
   );

   // ---------------- average divider ----------------
   scb_div #(
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (CNT_W'(last_ff) + 1'b1),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_aggregate = rsp_ff;

   // ---------------- assertions ----------------
   // A result only follows a busy cycle
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without preceding work");

   // Updates and dropped words never produce a result
   a_no_rsp_for_update: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation != OP_READ) |=> !rsp_strobe)
      else $error("result strobe for a non-read word");

   // Two results are never back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // The memory is written only in the cycle after an update fetch
   a_write_after_fetch: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> $past(accept))
      else $error("counter write without an accepted update");

endmodule
